// File: hw/rtl/hbc_pkg.sv
// Shared types and constants of the hashed block buffer cache.
// Used by hbc_mod, hbc_dp, hbc_ctrl and hashed_block_buffer_cache; no dependencies.
package hbc_pkg;

  localparam int unsigned SLOTS_DEF   = 32;
  localparam int unsigned BUCKETS_DEF = 13;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned DEV_W   = 8;
  localparam int unsigned BLK_W   = 32;
  localparam int unsigned SLOT_FW = 5;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned IN_TUSER_W  = KIND_W;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET     = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_PIN     = 3'd2,
    KIND_UNPIN   = 3'd3,
    KIND_FILL    = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch request, clear search state, start remainder
    logic scan_step;  // read next slot of the scan
    logic rd_single;  // read the addressed slot
    logic pick;       // register the replacement choice
    logic commit;     // write back and load the result register
  } hbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_get;
    logic scan_last;
    logic mod_done;
    logic out_free;
  } hbc_sts_t;

endpackage

// File: hw/rtl/hbc_mod.sv
// Remainder of a block number by the bucket count: fold the bytes through a constant
// remainder table over two registered stages. Depends on hbc_pkg.
module hbc_mod #(
  parameter int unsigned BUCKETS = hbc_pkg::BUCKETS_DEF,
  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hbc_pkg::BLK_W-1:0] value_i,
  output logic [BKT_W-1:0]         rem_o,
  output logic                     done_o
);
  import hbc_pkg::*;

  localparam int unsigned BYTES  = BLK_W / 8;
  localparam int unsigned CNT_MW = 2;
  localparam int unsigned STAGES = 2;

  logic [BKT_W-1:0]             mod_tbl [256];
  logic [BLK_W-1:0]             val_q, val_d;
  logic [BYTES-1:0][BKT_W-1:0]  part_q, part_d;
  logic [7:0]                   sum;
  logic [BKT_W-1:0]             rem_q, rem_d;
  logic [CNT_MW-1:0]            cnt_q, cnt_d;

  // remainder of every byte value, built at elaboration
  for (genvar v = 0; v < 256; v++) begin : g_tbl
    assign mod_tbl[v] = BKT_W'(v % BUCKETS);
  end

  // each byte contributes (byte mod B) * (256^k mod B); the product stays below 256 for BUCKETS up to 16
  for (genvar k = 0; k < BYTES; k++) begin : g_fold
    localparam int unsigned WT = (1 << (8 * k)) % BUCKETS;
    logic [7:0] prod;
    assign prod      = 8'(mod_tbl[val_q[8*k +: 8]]) * 8'(WT);
    assign part_d[k] = mod_tbl[prod];
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < BYTES; k++) begin
      sum = sum + 8'(part_q[k]);
    end
  end

  assign rem_d = mod_tbl[sum];

  always_comb begin
    val_d = val_q;
    cnt_d = cnt_q;
    if (start_i) begin
      val_d = value_i;
      cnt_d = CNT_MW'(STAGES);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_MW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    part_q <= part_d;
    rem_q  <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_o)
    else $error("remainder reported done right after start");

endmodule

// File: hw/rtl/hbc_dp.sv
// Datapath: request registers, slot memory, scan search, result register.
// Depends on hbc_pkg and hbc_mod.
module hbc_dp #(
  parameter int unsigned SLOTS   = hbc_pkg::SLOTS_DEF,
  parameter int unsigned BUCKETS = hbc_pkg::BUCKETS_DEF,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [hbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [hbc_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [hbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  hbc_pkg::hbc_cmd_t              cmd_i,
  output hbc_pkg::hbc_sts_t              sts_o
);
  import hbc_pkg::*;

  typedef struct packed {
    logic [BKT_W-1:0]  bkt;
    logic [TIME_W-1:0] tm;
    logic [CNT_W-1:0]  cnt;
    logic              cval;
    logic [BLK_W-1:0]  blk;
    logic [DEV_W-1:0]  dev;
  } ent_t;

  // request
  logic [KIND_W-1:0]  kind_q;
  logic [DEV_W-1:0]   dev_q;
  logic [BLK_W-1:0]   blk_q;
  logic [SLOT_FW-1:0] slot_q;
  logic [TIME_W-1:0]  now_q;
  logic               req_get;
  logic               in_range;

  // slot memory
  ent_t              mem [SLOTS];
  logic [SLOTS-1:0]  ent_vld_q;
  ent_t              rd_word_q;
  logic              rd_vld_q;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  ent_t              ent;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  ent_t              wr_word;

  // scan
  logic [SLOT_W-1:0] scan_cnt_q;
  logic              scan_vld_q;
  logic [SLOT_W-1:0] scan_idx_q;
  logic              hit_found_q;
  logic [SLOT_W-1:0] hit_idx_q;
  ent_t              hit_ent_q;
  logic              hit_now;
  logic [BUCKETS-1:0] bf_q;
  logic [TIME_W-1:0]  bt_q [BUCKETS];
  logic [SLOT_W-1:0]  bi_q [BUCKETS];
  logic              free_upd;

  // choice
  logic [BKT_W-1:0]  own;
  logic              mod_done;
  logic [BKT_W-1:0]  oth_idx;
  logic              any_free;
  logic              sel_ok_q;
  logic [SLOT_W-1:0] sel_idx_q;
  logic [TIME_W-1:0] sel_tm_q;
  logic [BKT_W-1:0]  own_q;

  // result
  logic [SLOT_FW-1:0] res_slot;
  logic               res_nr;
  status_e            res_st;
  logic               out_vld_q;
  logic [SLOT_FW-1:0] out_slot_q;
  logic               out_nr_q;
  logic [STAT_W-1:0]  out_st_q;

  hbc_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .value_i (s_axis_tdata_i[39:8]),
    .rem_o   (own),
    .done_o  (mod_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= s_axis_tuser_i;
      dev_q  <= s_axis_tdata_i[7:0];
      blk_q  <= s_axis_tdata_i[39:8];
      slot_q <= s_axis_tdata_i[44:40];
      now_q  <= s_axis_tdata_i[76:45];
    end
  end

  assign req_get  = (kind_q == KIND_GET);
  assign in_range = (int'(slot_q) < SLOTS);

  // memory: one read port, one write port, registered read
  assign rd_en   = cmd_i.scan_step | cmd_i.rd_single;
  assign rd_addr = cmd_i.scan_step ? scan_cnt_q : SLOT_W'(slot_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_word_q <= mem[rd_addr];
    end
  end

  // never-written entries read as the reset contents
  assign ent = rd_vld_q ? rd_word_q : '0;

  // tags only ever sit in the bucket of their own block number, so a tag
  // match alone identifies the hit
  assign hit_now  = scan_vld_q && !hit_found_q && (ent.dev == dev_q) && (ent.blk == blk_q);
  assign free_upd = scan_vld_q && (ent.cnt == '0) && (int'(ent.bkt) < BUCKETS) &&
                    (!bf_q[ent.bkt] || (ent.tm < bt_q[ent.bkt]));

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_cnt_q;
    if (hit_now) begin
      hit_idx_q <= scan_idx_q;
      hit_ent_q <= ent;
    end
    if (free_upd) begin
      bt_q[ent.bkt] <= ent.tm;
      bi_q[ent.bkt] <= scan_idx_q;
    end
  end

  // first other bucket in order that holds a free slot
  always_comb begin
    oth_idx  = '0;
    any_free = |bf_q;
    for (int j = BUCKETS - 1; j >= 0; j--) begin
      if (bf_q[j]) begin
        oth_idx = BKT_W'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      own_q    <= own;
      sel_ok_q <= bf_q[own] | any_free;
      if (bf_q[own]) begin
        sel_idx_q <= bi_q[own];
        sel_tm_q  <= bt_q[own];
      end else begin
        sel_idx_q <= bi_q[oth_idx];
        sel_tm_q  <= bt_q[oth_idx];
      end
    end
  end

  // write-back and result
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = SLOT_W'(slot_q);
    wr_word  = ent;
    res_slot = slot_q;
    res_nr   = 1'b0;
    res_st   = ST_OK;
    if (req_get) begin
      if (hit_found_q) begin
        res_slot = SLOT_FW'(hit_idx_q);
        res_nr   = !hit_ent_q.cval;
        wr_addr  = hit_idx_q;
        wr_word  = hit_ent_q;
        if (hit_ent_q.cnt == COUNT_MAX) begin
          res_st = ST_SAT;
        end else begin
          wr_en       = 1'b1;
          wr_word.cnt = hit_ent_q.cnt + CNT_W'(1);
        end
      end else if (sel_ok_q) begin
        wr_en        = 1'b1;
        wr_addr      = sel_idx_q;
        wr_word.bkt  = own_q;
        wr_word.tm   = sel_tm_q;
        wr_word.cnt  = CNT_W'(1);
        wr_word.cval = 1'b0;
        wr_word.blk  = blk_q;
        wr_word.dev  = dev_q;
        res_slot     = SLOT_FW'(sel_idx_q);
        res_nr       = 1'b1;
      end else begin
        res_slot = '0;
        res_st   = ST_NOFREE;
      end
    end else if (in_range) begin
      unique case (kind_q)
        KIND_RELEASE, KIND_UNPIN: begin
          if (ent.cnt == '0) begin
            res_st = ST_UNDER;
          end else begin
            wr_en       = 1'b1;
            wr_word.cnt = ent.cnt - CNT_W'(1);
            if (kind_q == KIND_RELEASE && ent.cnt == CNT_W'(1)) begin
              wr_word.tm = now_q;
            end
          end
        end
        KIND_PIN: begin
          if (ent.cnt == COUNT_MAX) begin
            res_st = ST_SAT;
          end else begin
            wr_en       = 1'b1;
            wr_word.cnt = ent.cnt + CNT_W'(1);
          end
        end
        KIND_FILL: begin
          wr_en        = 1'b1;
          wr_word.cval = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    wr_en = wr_en & cmd_i.commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      scan_cnt_q  <= '0;
      scan_vld_q  <= 1'b0;
      hit_found_q <= 1'b0;
      bf_q        <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= ent_vld_q[rd_addr];
      end
      scan_vld_q <= cmd_i.scan_step;
      if (cmd_i.load) begin
        scan_cnt_q  <= '0;
        hit_found_q <= 1'b0;
        bf_q        <= '0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_cnt_q <= scan_cnt_q + SLOT_W'(1);
        end
        if (hit_now) begin
          hit_found_q <= 1'b1;
        end
        if (free_upd) begin
          bf_q[ent.bkt] <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_slot_q <= res_slot;
      out_nr_q   <= res_nr;
      out_st_q   <= res_st;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_st_q, out_nr_q, out_slot_q};

  assign sts_o.in_get    = (s_axis_tuser_i == KIND_GET);
  assign sts_o.scan_last = (scan_cnt_q == SLOT_W'(SLOTS - 1));
  assign sts_o.mod_done  = mod_done;
  assign sts_o.out_free  = !out_vld_q || m_axis_tready_i;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_vld_q)
    else $error("committed transaction not presented");

  a_scan_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_vld_q |-> req_get)
    else $error("scan data returned for a request other than get");

endmodule

// File: hw/rtl/hbc_ctrl.sv
// Controller state machine: sequences load, single-slot read or scan, pick and write-back.
// Depends on hbc_pkg.
module hbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  hbc_pkg::hbc_sts_t sts_i,
  output hbc_pkg::hbc_cmd_t cmd_o
);
  import hbc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_PICK  = 6'b010000,
    S_WR    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_get ? S_SCAN : S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_single = 1'b1;
        state_d         = S_WR;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // last read lands here; hold until the bucket number is known
      S_DRAIN: begin
        if (sts_i.mod_done) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result register overwritten");

  a_drain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && !sts_i.mod_done) |=> (state_q == S_DRAIN))
    else $error("pick started before bucket number ready");

endmodule

// File: hw/rtl/hashed_block_buffer_cache.sv
// Hashed block buffer cache: tag lookup and oldest-free replacement per bucket.
// Release, pin, unpin, fill done and unknown kinds: read the addressed slot, then write back.
// Get: scans one slot a cycle over SLOTS reads, then drains the last read data and waits for the bucket
// number, then picks and writes back; the bucket number is computed alongside the scan.
// One transaction at a time; the next is accepted the cycle after the result is registered.
// Reset (async, active low) clears control and per-slot valid bits; no clearing pass.
module hashed_block_buffer_cache #(
  parameter int unsigned SLOTS   = hbc_pkg::SLOTS_DEF,
  parameter int unsigned BUCKETS = hbc_pkg::BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] device, [39:8] block_number, [44:40] slot, [76:45] now, [79:77] zero
  input  logic [hbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [hbc_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [4:0] slot_out, [5] needs_read, [7:6] status
  output logic [hbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import hbc_pkg::*;

  hbc_cmd_t cmd;
  hbc_sts_t sts;

  hbc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  hbc_dp #(
    .SLOTS   (SLOTS),
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: verif/hashed_block_buffer_cache_tb.sv
// Testbench for hashed_block_buffer_cache: get, release, pin, unpin, fill-done and unknown-kind requests,
// checked against a cycle-free predictor of tags, counts, ages and buckets.
// Depends on hbc_pkg and the hashed_block_buffer_cache RTL only.
`timescale 1ns / 100ps

module hashed_block_buffer_cache_tb;
  import hbc_pkg::*;

  localparam int unsigned SLOTS          = SLOTS_DEF;
  localparam int unsigned BUCKETS        = BUCKETS_DEF;
  localparam int unsigned BKT_W          = 4;
  localparam int unsigned IN_USED_W      = DEV_W + BLK_W + SLOT_FW + TIME_W;
  localparam int unsigned GAP_MAX        = 12;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned TAIL_CYCLES    = 60;

  typedef enum logic [1:0] {
    SRC_GIVEN,
    SRC_LAST_GRANT,
    SRC_OLDEST_HOLD
  } slot_src_e;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [SLOT_FW-1:0] slot;
    logic [TIME_W-1:0]  now;
    slot_src_e          src;
    int unsigned        gap;
    bit                 drain_first;
    bit                 hold_rx;
  } request_t;

  // packs as tdata: [4:0] slot_out, [5] needs_read, [7:6] status
  typedef struct packed {
    status_e            status;
    logic               needs_read;
    logic [SLOT_FW-1:0] slot_out;
  } answer_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  hashed_block_buffer_cache #(
    .SLOTS   (SLOTS),
    .BUCKETS (BUCKETS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // predicted cache state
  logic [DEV_W-1:0]  dev_tag   [SLOTS];
  logic [BLK_W-1:0]  blk_tag   [SLOTS];
  logic              filled    [SLOTS];
  logic [CNT_W-1:0]  refs      [SLOTS];
  logic [TIME_W-1:0] last_used [SLOTS];
  logic [BKT_W-1:0]  bucket_of [SLOTS];

  request_t          pending_requests[$];
  answer_t           expected_answers[$];
  logic [SLOT_FW-1:0] held_slots[$];
  logic [SLOT_FW-1:0] last_grant = '0;
  request_t          in_flight;

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned gap_left     = 0;
  int unsigned hold_reqs    = 0;
  int unsigned holds_done   = 0;
  int unsigned stall_left   = 0;
  int unsigned rx_wait      = 0;
  int unsigned rx_count     = 0;
  bit          rx_calm      = 1'b0;
  int unsigned errors       = 0;

  // stimulus generator state
  logic [TIME_W-1:0] clock_tick = '0;
  int unsigned       gap_cap    = GAP_MAX;
  int unsigned       issued     = 0;
  logic [BLK_W-1:0]  blk_pool [40];
  logic [DEV_W-1:0]  dev_pool [4];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      dev_tag[i]   = '0;
      blk_tag[i]   = '0;
      filled[i]    = 1'b0;
      refs[i]      = '0;
      last_used[i] = '0;
      bucket_of[i] = '0;
    end
  end

  function automatic int oldest_free_in(int b);
    int pick = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (bucket_of[i] == b && refs[i] == 0 && (pick < 0 || last_used[i] < last_used[pick]))
        pick = i;
    end
    return pick;
  endfunction

  // Apply one request to the predicted state and return its answer.
  function automatic answer_t serve_request(request_t r);
    answer_t a;
    int      hit;
    int      pick;
    int      home;
    a.slot_out   = r.slot;
    a.needs_read = 1'b0;
    a.status     = ST_OK;
    hit  = -1;
    pick = -1;
    if (r.kind == KIND_GET) begin
      home = int'(r.blk % BUCKETS);
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && bucket_of[i] == home && dev_tag[i] == r.dev && blk_tag[i] == r.blk)
          hit = i;
      end
      if (hit >= 0) begin
        if (refs[hit] == COUNT_MAX) a.status = ST_SAT;
        else refs[hit] = refs[hit] + 1'b1;
        a.slot_out   = SLOT_FW'(hit);
        a.needs_read = !filled[hit];
      end else begin
        pick = oldest_free_in(home);
        for (int b = 0; b < BUCKETS && pick < 0; b++) begin
          if (b != home) pick = oldest_free_in(b);
        end
        if (pick < 0) begin
          a.slot_out = '0;
          a.status   = ST_NOFREE;
        end else begin
          bucket_of[pick] = BKT_W'(home);
          dev_tag[pick]   = r.dev;
          blk_tag[pick]   = r.blk;
          filled[pick]    = 1'b0;
          refs[pick]      = CNT_W'(1);
          a.slot_out      = SLOT_FW'(pick);
          a.needs_read    = 1'b1;
        end
      end
    end else if (r.kind == KIND_RELEASE || r.kind == KIND_UNPIN) begin
      if (refs[r.slot] == 0) begin
        a.status = ST_UNDER;
      end else begin
        refs[r.slot] = refs[r.slot] - 1'b1;
        if (r.kind == KIND_RELEASE && refs[r.slot] == 0) last_used[r.slot] = r.now;
      end
    end else if (r.kind == KIND_PIN) begin
      if (refs[r.slot] == COUNT_MAX) a.status = ST_SAT;
      else refs[r.slot] = refs[r.slot] + 1'b1;
    end else if (r.kind == KIND_FILL) begin
      filled[r.slot] = 1'b1;
    end
    return a;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sender: one transaction offered at a time, gaps drawn per item
  always @(posedge clk_i) begin : drive_proc
    answer_t want;
    bit      fire;
    bit      launch;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      fire   = s_tvalid && s_tready;
      launch = 1'b0;
      if (fire) begin
        want = serve_request(in_flight);
        expected_answers.push_back(want);
        items_sent++;
        if (in_flight.kind == KIND_GET && want.status != ST_NOFREE) begin
          last_grant = want.slot_out;
          held_slots.push_back(want.slot_out);
        end
        if (in_flight.hold_rx) hold_reqs <= hold_reqs + 1;
        gap_left = (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
      end
      if (fire || !s_tvalid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0 &&
                     (!pending_requests[0].drain_first || items_sent == results_seen)) begin
          in_flight = pending_requests.pop_front();
          // resolve the slot from grants seen so far
          if (in_flight.src == SRC_LAST_GRANT) begin
            in_flight.slot = last_grant;
          end else if (in_flight.src == SRC_OLDEST_HOLD && held_slots.size() != 0) begin
            in_flight.slot = held_slots.pop_front();
          end
          launch = 1'b1;
        end
        s_tvalid <= launch;
        if (launch) begin
          s_tdata <= {{(IN_TDATA_W-IN_USED_W){1'b0}}, in_flight.now, in_flight.slot,
                      in_flight.blk, in_flight.dev};
          s_tuser <= in_flight.kind;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (holds_done != hold_reqs) begin
      stall_left <= RX_HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : watch_proc
    answer_t got;
    answer_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = answer_t'(m_tdata);
        if (expected_answers.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (got.slot_out !== want.slot_out) begin
            $display("%0t: slot_out: expected %0d, got %0d", $time, want.slot_out, got.slot_out);
            errors++;
          end
          if (got.needs_read !== want.needs_read) begin
            $display("%0t: needs_read: expected %0b, got %0b", $time, want.needs_read,
                     got.needs_read);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status: expected %0d, got %0d", $time, want.status, got.status);
            errors++;
          end
        end
        results_seen <= results_seen + 1;
        rx_count++;
        // alternate stretches of random back-pressure and none
        if (rx_count % 150 == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && (stall_left == 0);
    end
  end

  task automatic add_req(input logic [KIND_W-1:0] kind, input logic [DEV_W-1:0] dev,
                         input logic [BLK_W-1:0] blk, input logic [SLOT_FW-1:0] slot,
                         input slot_src_e src);
    request_t r;
    clock_tick    = clock_tick + $urandom_range(1, 4000);
    r.kind        = kind;
    r.dev         = dev;
    r.blk         = blk;
    r.slot        = slot;
    r.now         = clock_tick;
    r.src         = src;
    r.gap         = $urandom_range(0, gap_cap);
    r.drain_first = 1'b0;
    r.hold_rx     = 1'b0;
    pending_requests.push_back(r);
    if (kind <= KIND_FILL) issued++;
  endtask

  task automatic add_noise();
    add_req(KIND_W'($urandom_range(0, (1 << KIND_W) - 1)), DEV_W'($urandom), $urandom,
            SLOT_FW'($urandom), SRC_GIVEN);
    pending_requests[$].now = $urandom;
  endtask

  // one step of ordinary use: lookups with fills, releases of held slots, pins, unpins, fills and noise
  task automatic add_usage_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      add_req(KIND_GET, dev_pool[$urandom_range(0, 3)], blk_pool[$urandom_range(0, 39)],
              SLOT_FW'($urandom), SRC_GIVEN);
      if ($urandom_range(0, 1) == 1)
        add_req(KIND_FILL, DEV_W'($urandom), $urandom, '0, SRC_LAST_GRANT);
    end else if (roll < 75) begin
      add_req(KIND_RELEASE, DEV_W'($urandom), $urandom, SLOT_FW'($urandom), SRC_OLDEST_HOLD);
    end else if (roll < 83) begin
      add_req(KIND_PIN, DEV_W'($urandom), $urandom, '0, SRC_LAST_GRANT);
    end else if (roll < 90) begin
      add_req(KIND_UNPIN, DEV_W'($urandom), $urandom, '0, SRC_LAST_GRANT);
    end else if (roll < 95) begin
      add_req(KIND_FILL, DEV_W'($urandom), $urandom, SLOT_FW'($urandom), SRC_GIVEN);
    end else begin
      add_noise();
    end
  endtask

  initial begin : stimulus_proc
    logic [BLK_W-1:0] sat_blk;
    int unsigned      target;
    int unsigned      chunk;
    int unsigned      len;

    dev_pool[0] = '0;
    dev_pool[1] = '1;
    dev_pool[2] = DEV_W'($urandom);
    dev_pool[3] = DEV_W'($urandom);
    // half spread over all buckets, half crowded into three to force stealing
    for (int i = 0; i < 40; i++)
      blk_pool[i] = (i < 20) ? $urandom : BLK_W'(BUCKETS * $urandom_range(0, 300000) + i % 3);
    blk_pool[0] = '1;

    // directed: zero tag hits slot 0, extremes, every kind, underflow, unknown kinds
    add_req(KIND_GET, '0, '0, '1, SRC_GIVEN);
    add_req(KIND_GET, '1, '1, '0, SRC_GIVEN);
    add_req(KIND_FILL, '0, '0, '0, SRC_LAST_GRANT);
    add_req(KIND_GET, '1, '1, '1, SRC_GIVEN);
    add_req(KIND_PIN, '0, '0, '0, SRC_LAST_GRANT);
    add_req(KIND_UNPIN, '0, '0, '0, SRC_LAST_GRANT);
    add_req(KIND_RELEASE, '0, '0, '0, SRC_LAST_GRANT);
    add_req(KIND_RELEASE, '1, '1, '0, SRC_LAST_GRANT);
    pending_requests[$].now = '1;
    add_req(KIND_RELEASE, '0, '0, '0, SRC_LAST_GRANT);
    add_req(KIND_UNPIN, '0, '0, '1, SRC_GIVEN);
    add_req(KIND_PIN, '0, '0, '1, SRC_GIVEN);
    add_req(KIND_RELEASE, '0, '0, '1, SRC_GIVEN);
    pending_requests[$].now = '0;
    add_req(KIND_FILL, '0, '0, '0, SRC_GIVEN);
    add_req(KIND_RELEASE, '0, '0, '0, SRC_GIVEN);
    for (int k = int'(KIND_FILL) + 1; k < (1 << KIND_W); k++)
      add_req(KIND_W'(k), '1, '1, '1, SRC_GIVEN);
    add_req(KIND_GET, 8'd1, BLK_W'(BUCKETS), '0, SRC_GIVEN);
    add_req(KIND_GET, 8'd1, BLK_W'(2 * BUCKETS), '0, SRC_GIVEN);
    add_req(KIND_RELEASE, '0, '0, '0, SRC_OLDEST_HOLD);
    // hold the sender until every result so far has come back
    pending_requests[$].drain_first = 1'b1;

    target = RANDOM_ITEMS;

    // drive one slot to saturation and back
    sat_blk = $urandom;
    add_req(KIND_GET, 8'h5A, sat_blk, '0, SRC_GIVEN);
    for (int i = 0; i < int'(COUNT_MAX); i++)
      add_req(KIND_PIN, DEV_W'($urandom), $urandom, '0, SRC_LAST_GRANT);
    add_req(KIND_GET, 8'h5A, sat_blk, '0, SRC_GIVEN);
    for (int i = 0; i < int'(COUNT_MAX) - 1; i++)
      add_req(KIND_UNPIN, DEV_W'($urandom), $urandom, '0, SRC_LAST_GRANT);
    add_req(KIND_RELEASE, '0, '0, '0, SRC_LAST_GRANT);
    add_req(KIND_RELEASE, '0, '0, '0, SRC_LAST_GRANT);

    // stall the receiver early while the sender keeps offering
    pending_requests[$].hold_rx = 1'b1;

    while (issued < target) begin
      chunk = $urandom_range(0, 9);
      len   = $urandom_range(10, 40);
      if (chunk <= 4) begin
        for (int i = 0; i < len; i++) add_usage_op();
      end else if (chunk <= 6) begin
        for (int i = 0; i < len; i++)
          add_req(KIND_RELEASE, DEV_W'($urandom), $urandom, SLOT_FW'($urandom),
                  SRC_OLDEST_HOLD);
      end else if (chunk == 7) begin
        // fill every slot, overflow with two extra gets, then hand them back
        for (int i = 0; i <= SLOTS + 1; i++)
          add_req(KIND_GET, DEV_W'($urandom), $urandom, '0, SRC_GIVEN);
        for (int i = 0; i <= SLOTS + 1; i++)
          add_req(KIND_RELEASE, '0, '0, '0, SRC_OLDEST_HOLD);
      end else if (chunk == 8) begin
        for (int i = 0; i < len / 2; i++) add_noise();
      end else begin
        gap_cap = 0;
        add_usage_op();
        pending_requests[$].drain_first = 1'b1;
        if ($urandom_range(0, 2) == 0) pending_requests[$].hold_rx = 1'b1;
        for (int i = 0; i < len; i++) add_usage_op();
        gap_cap = GAP_MAX;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_tvalid || items_sent != results_seen)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      $display("%0t: results missing: expected %0d more, got none", $time,
               expected_answers.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: hashed_block_buffer_cache.f
hw/rtl/hbc_pkg.sv
hw/rtl/hbc_mod.sv
hw/rtl/hbc_dp.sv
hw/rtl/hbc_ctrl.sv
hw/rtl/hashed_block_buffer_cache.sv
verif/hashed_block_buffer_cache_tb.sv
